@@ rtl/vhsc_pkg.sv @@
// Shared types, constants and the signature table of the Vorbis header checker.
`default_nettype none
package vhsc_pkg;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_SIGNATURE = 4'd2,
    ST_ORDER     = 4'd3,
    ST_VERSION   = 4'd4,
    ST_CHANNELS  = 4'd5,
    ST_RATE      = 4'd6,
    ST_FRAMING   = 4'd7,
    ST_UNKNOWN   = 4'd8
  } status_t;

  localparam logic [7:0] TYPE_ID      = 8'd1;
  localparam logic [7:0] TYPE_COMMENT = 8'd3;
  localparam logic [7:0] TYPE_SETUP   = 8'd5;

  localparam logic [4:0] POS_SAT      = 5'd30;
  localparam logic [4:0] POS_FRAME    = 5'd29;
  localparam logic [4:0] POS_CHANNELS = 5'd11;
  // A last byte at an offset below these leaves the packet too short (length = offset + 1).
  localparam logic [4:0] POS_MIN_LAST = 5'd6;
  localparam logic [4:0] POS_ID_LAST  = 5'd29;

  localparam logic [1:0] COUNT_NONE    = 2'd0;
  localparam logic [1:0] COUNT_ID      = 2'd1;
  localparam logic [1:0] COUNT_COMMENT = 2'd2;
  localparam logic [1:0] COUNT_ALL     = 2'd3;

  // Packet observations including the byte now being evaluated.
  typedef struct packed {
    logic [7:0]  header_type;
    logic        sig_mismatch;
    logic        version_nonzero;
    logic [7:0]  channels;
    logic [31:0] rate;
    logic        framing;
    logic        too_short;
    logic        id_too_short;
  } obs_t;

  // One verdict as it leaves the block.
  typedef struct packed {
    logic        accepted;
    status_t     status;
    logic [7:0]  header_type;
    logic [1:0]  headers_accepted;
    logic        all_headers_done;
    logic [7:0]  channels;
    logic [31:0] sample_rate;
  } result_t;

  // Expected byte of the text "vorbis" at packet offsets one to six.
  function automatic logic [7:0] sig_byte(input logic [4:0] pos);
    logic [7:0] value;
    case (pos)
      5'd1:    value = 8'h76;
      5'd2:    value = 8'h6F;
      5'd3:    value = 8'h72;
      5'd4:    value = 8'h62;
      5'd5:    value = 8'h69;
      5'd6:    value = 8'h73;
      default: value = 8'h00;
    endcase
    return value;
  endfunction

endpackage
`default_nettype wire

@@ rtl/vhsc_observe.sv @@
// Per-packet byte position and field observations.
`default_nettype none
module vhsc_observe (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      packet_byte,
  input  wire logic            last_byte,
  output vhsc_pkg::obs_t       obs
);

  logic [4:0]  pos;
  logic [7:0]  type_seen;
  logic        signature_mismatch;
  logic        version_nonzero;
  logic [7:0]  pending_channels;
  logic [31:0] pending_rate;
  logic        id_framing_bit;

  logic [4:0]  pos_next;

  always_comb begin
    obs.header_type     = (pos == 5'd0) ? packet_byte : type_seen;
    obs.sig_mismatch    = signature_mismatch;
    obs.version_nonzero = version_nonzero;
    obs.channels        = (pos == vhsc_pkg::POS_CHANNELS) ? packet_byte : pending_channels;
    obs.rate            = pending_rate;
    obs.framing         = (pos == vhsc_pkg::POS_FRAME) ? packet_byte[0] : id_framing_bit;
    obs.too_short       = (pos < vhsc_pkg::POS_MIN_LAST);
    obs.id_too_short    = (pos < vhsc_pkg::POS_ID_LAST);
    if (pos inside {[5'd1:5'd6]} && packet_byte != vhsc_pkg::sig_byte(pos)) begin
      obs.sig_mismatch = 1'b1;
    end
    if (pos inside {[5'd7:5'd10]} && packet_byte != 8'd0) begin
      obs.version_nonzero = 1'b1;
    end
    // Rate bytes sit little-endian at offsets 12 to 15; the low two bits pick the lane.
    if (pos inside {[5'd12:5'd15]}) begin
      obs.rate = pending_rate | ({24'd0, packet_byte} << {pos[1:0], 3'b000});
    end
    pos_next = (pos < vhsc_pkg::POS_SAT) ? pos + 5'd1 : vhsc_pkg::POS_SAT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos                <= 5'd0;
      type_seen          <= 8'd0;
      signature_mismatch <= 1'b0;
      version_nonzero    <= 1'b0;
      pending_channels   <= 8'd0;
      pending_rate       <= 32'd0;
      id_framing_bit     <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        pos                <= 5'd0;
        type_seen          <= 8'd0;
        signature_mismatch <= 1'b0;
        version_nonzero    <= 1'b0;
        pending_channels   <= 8'd0;
        pending_rate       <= 32'd0;
        id_framing_bit     <= 1'b0;
      end else begin
        pos                <= pos_next;
        type_seen          <= obs.header_type;
        signature_mismatch <= obs.sig_mismatch;
        version_nonzero    <= obs.version_nonzero;
        pending_channels   <= obs.channels;
        pending_rate       <= obs.rate;
        id_framing_bit     <= obs.framing;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/vhsc_judge.sv @@
// Verdict logic, header sequence count and committed stream parameters.
`default_nettype none
module vhsc_judge (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step_last,
  input  wire vhsc_pkg::obs_t  obs,
  input  wire logic            last_bit,
  output vhsc_pkg::result_t    result
);

  logic [1:0]        header_count;
  logic [7:0]        committed_channels;
  logic [31:0]       committed_rate;

  vhsc_pkg::status_t status;
  logic [1:0]        header_count_next;
  logic              ok;

  always_comb begin
    header_count_next = header_count;
    if (obs.too_short) begin
      status = vhsc_pkg::ST_SHORT;
    end else if (obs.sig_mismatch) begin
      status = vhsc_pkg::ST_SIGNATURE;
    end else begin
      case (obs.header_type)
        vhsc_pkg::TYPE_ID: begin
          if (header_count != vhsc_pkg::COUNT_NONE)  status = vhsc_pkg::ST_ORDER;
          else if (obs.id_too_short)                 status = vhsc_pkg::ST_SHORT;
          else if (obs.version_nonzero)              status = vhsc_pkg::ST_VERSION;
          else if (obs.channels == 8'd0)             status = vhsc_pkg::ST_CHANNELS;
          else if (obs.rate == 32'd0)                status = vhsc_pkg::ST_RATE;
          else if (!obs.framing)                     status = vhsc_pkg::ST_FRAMING;
          else begin
            status            = vhsc_pkg::ST_OK;
            header_count_next = vhsc_pkg::COUNT_ID;
          end
        end
        vhsc_pkg::TYPE_COMMENT: begin
          if (header_count != vhsc_pkg::COUNT_ID)    status = vhsc_pkg::ST_ORDER;
          else if (!last_bit)                        status = vhsc_pkg::ST_FRAMING;
          else begin
            status            = vhsc_pkg::ST_OK;
            header_count_next = vhsc_pkg::COUNT_COMMENT;
          end
        end
        vhsc_pkg::TYPE_SETUP: begin
          if (header_count != vhsc_pkg::COUNT_COMMENT) status = vhsc_pkg::ST_ORDER;
          else if (!last_bit)                          status = vhsc_pkg::ST_FRAMING;
          else begin
            status            = vhsc_pkg::ST_OK;
            header_count_next = vhsc_pkg::COUNT_ALL;
          end
        end
        default: status = vhsc_pkg::ST_UNKNOWN;
      endcase
    end
    ok = (status == vhsc_pkg::ST_OK);

    result.accepted         = ok;
    result.status           = status;
    result.header_type      = obs.header_type;
    result.headers_accepted = header_count_next;
    result.all_headers_done = (header_count_next == vhsc_pkg::COUNT_ALL);
    // Only an accepted identification header carries fresh channels and rate.
    if (ok && obs.header_type == vhsc_pkg::TYPE_ID) begin
      result.channels    = obs.channels;
      result.sample_rate = obs.rate;
    end else begin
      result.channels    = committed_channels;
      result.sample_rate = committed_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count       <= vhsc_pkg::COUNT_NONE;
      committed_channels <= 8'd0;
      committed_rate     <= 32'd0;
    end else if (step_last) begin
      header_count       <= header_count_next;
      committed_channels <= result.channels;
      committed_rate     <= result.sample_rate;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vorbis_header_sequence_checker.sv @@
// Top level of the Vorbis header sequence checker with input and result registers.
`default_nettype none
// Accepts one header packet byte per cycle, with last_byte marking the end of a
// packet, and returns one verdict item per packet. A byte is captured in an input
// register and evaluated from it; a packet's last byte waits there until the
// result register is free, which then offers the verdict. Throughput is one byte
// per cycle for as long as results are taken; the single result register is what
// holds the stream back when res_ready stays low. The verdict checks length,
// signature, header order, framing and the identification fields; channels and
// sample_rate report the values of the last accepted identification header.
module vorbis_header_sequence_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pkt_valid,
  output logic             pkt_ready,
  input  wire logic [7:0]  packet_byte,
  input  wire logic        last_byte,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             accepted,
  output logic [3:0]       status,
  output logic [7:0]       header_type,
  output logic [1:0]       headers_accepted,
  output logic             all_headers_done,
  output logic [7:0]       channels,
  output logic [31:0]      sample_rate
);

  logic              ir_valid;
  logic [7:0]        ir_byte;
  logic              ir_last;

  logic              out_free;
  logic              advance;
  logic              step_last;
  vhsc_pkg::obs_t    obs;
  vhsc_pkg::result_t verdict;
  vhsc_pkg::result_t res;

  assign out_free  = !res_valid || res_ready;
  assign advance   = ir_valid && (!ir_last || out_free);
  assign step_last = advance && ir_last;
  assign pkt_ready = !ir_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (pkt_valid && pkt_ready) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid && pkt_ready) begin
      ir_byte <= packet_byte;
      ir_last <= last_byte;
    end
  end

  vhsc_observe u_observe (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .packet_byte (ir_byte),
    .last_byte   (ir_last),
    .obs         (obs)
  );

  vhsc_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .step_last (step_last),
    .obs       (obs),
    .last_bit  (ir_byte[0]),
    .result    (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_last) begin
      res <= verdict;
    end
  end

  assign accepted         = res.accepted;
  assign status           = res.status;
  assign header_type      = res.header_type;
  assign headers_accepted = res.headers_accepted;
  assign all_headers_done = res.all_headers_done;
  assign channels         = res.channels;
  assign sample_rate      = res.sample_rate;

`ifndef SYNTHESIS
  a_accept_matches_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (accepted == (status == vhsc_pkg::ST_OK)))
    else $error("accepted flag disagrees with status");

  a_done_matches_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (all_headers_done == (headers_accepted == vhsc_pkg::COUNT_ALL)))
    else $error("all_headers_done disagrees with header count");

  a_id_commit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && accepted && header_type == vhsc_pkg::TYPE_ID) |->
      (channels != 8'd0 && sample_rate != 32'd0 && headers_accepted == vhsc_pkg::COUNT_ID))
    else $error("accepted identification header committed bad values");

  a_result_needs_last: assert property (@(posedge clk) disable iff (rst)
    step_last |-> (ir_valid && ir_last && out_free))
    else $error("verdict loaded without a pending last item");
`endif

endmodule
`default_nettype wire
